// ===== hdl/ewf_pkg.sv =====
package ewf_pkg;

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 16;
    localparam int RAD_W    = 3;
    localparam int WCFG_W   = 11;
    localparam int HEIGHT_W = 13;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int         APB_ADDR_W = 4;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_KPOS,
        ST_JPOS,
        ST_LAG,
        ST_CHECK,
        ST_DECIDE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_FINISH
    } ewf_state_t;

    typedef enum logic [1:0] {
        MUL_TOTAL,
        MUL_KPOS,
        MUL_JPOS,
        MUL_LAG
    } ewf_mul_sel_t;

    typedef struct packed {
        logic         capture;
        logic         mul_en;
        ewf_mul_sel_t mul_sel;
        logic         clear_cnt;
        logic         scan_init;
        logic         scan_step;
        logic         finish;
    } ewf_cmd_t;

    typedef struct packed {
        logic geom_bad;
        logic skip;
        logic emit;
        logic scan_last;
        logic out_busy;
    } ewf_status_t;

endpackage

// ===== hdl/ewf_if.sv =====
interface ewf_pix_if import ewf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output opcode, output pixel_value, input ready);
    modport sink   (input valid, input opcode, input pixel_value, output ready);
endinterface

interface ewf_res_if import ewf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] result_pixel;
    logic             end_of_frame;

    modport source (output valid, output result_pixel, output end_of_frame, input ready);
    modport sink   (input valid, input result_pixel, input end_of_frame, output ready);
endinterface

// ===== hdl/extremum_window_filter.sv =====
// Channel   | Dir | Handshake        | Payload
// pix_in    | in  | valid / ready    | opcode, pixel_value
// res_out   | out | valid / ready    | result_pixel, end_of_frame
// apb       | in  | psel / penable   | paddr[3:0], pwdata, prdata (pready tied high)
//
// Each item walks IDLE, TOTAL..LAG (shared geometry multiplier), CHECK, DECIDE;
// a drain before frame end stops there, others go on to FINISH, and an item with
// a result scans up to (2R+1)^2 cells, one read each on the single line-store port.
// Reset: rst_n async low clears counters and control; line store is not cleared.
// A finished result sits in the output register; the next item is taken and
// worked, and only its own result load waits on a stalled res_out.
module extremum_window_filter import ewf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ewf_pix_if.sink               pix_in,
    ewf_res_if.source             res_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [WCFG_W-1:0]   width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [RAD_W-1:0]    radius_reg;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    logic [CW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [RAD_W-1:0]    rad_eff;

    ewf_cmd_t            cmd;
    ewf_status_t         st;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WCFG_W'(640);
            height_reg <= HEIGHT_W'(480);
            radius_reg <= RAD_W'(1);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[WCFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_W-1:0];
                REG_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_RADIUS: prdata = 32'(radius_reg);
            default:    prdata = '0;
        endcase
    end

    // width 0 acts as 1 and clamps at MAX_WIDTH; height 0 acts as 1
    assign w_eff   = (width_reg == '0) ? CW'(1) :
                     (32'(width_reg) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_reg);
    assign h_eff   = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    assign rad_eff = (32'(radius_reg) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_reg;

    ewf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .st       (st),
        .cmd      (cmd)
    );

    ewf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .rad_eff   (rad_eff),
        .in_opcode (pix_in.opcode),
        .in_pixel  (pix_in.pixel_value),
        .cmd       (cmd),
        .st        (st),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .out_pixel (res_out.result_pixel),
        .out_eof   (res_out.end_of_frame)
    );

endmodule

// ===== hdl/ewf_ram.sv =====
module ewf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ewf_ctrl.sv =====
module ewf_ctrl import ewf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ewf_status_t st,
    output ewf_cmd_t    cmd
);

    ewf_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.mul_sel   = MUL_TOTAL;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TOTAL;
                state_next  = ST_KPOS;
            end
            ST_KPOS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KPOS;
                state_next  = ST_JPOS;
            end
            ST_JPOS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_JPOS;
                state_next  = ST_LAG;
            end
            ST_LAG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LAG;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.clear_cnt = st.geom_bad;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (st.skip)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.emit)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    state_next = ST_SCAN_LAST;
                end
            end
            ST_SCAN_LAST:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!(st.emit && st.out_busy))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ewf_dp.sv =====
module ewf_dp import ewf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] w_eff,
    input  logic [HEIGHT_W-1:0]            h_eff,
    input  logic [RAD_W-1:0]               rad_eff,
    input  logic                           in_opcode,
    input  logic [PIX_W-1:0]               in_pixel,
    input  ewf_cmd_t                       cmd,
    output ewf_status_t                    st,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [PIX_W-1:0]               out_pixel,
    output logic                           out_eof
);

    localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int CW         = $clog2(MAX_WIDTH + 1);
    localparam int CX         = CW + 1;
    localparam int RX         = ROW_W + 1;
    localparam int SW         = $clog2(STORE_ROWS);
    localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int PW         = ROW_W + CW;

    // captured item
    logic             op_reg;
    logic [PIX_W-1:0] pix_reg;

    // raster counters, slot = row mod STORE_ROWS
    logic [CW-1:0]    icol_reg, icol_next, ocol_reg, ocol_next;
    logic [ROW_W-1:0] irow_reg, irow_next, orow_reg, orow_next;
    logic [SW-1:0]    islot_reg, islot_next, oslot_reg, oslot_next;

    // raster positions
    logic [PW-1:0] total_reg, kpos_reg, jpos_reg, lag_reg;
    logic [PW-1:0] kpos_next, jpos_next;

    // window scan
    logic [ROW_W-1:0] r_reg, r_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic             rd_valid_reg, centre_flag_reg, sub_flag_reg;
    logic [PIX_W-1:0] lo_reg, lo_next, hi_reg, hi_next, centre_reg, centre_next;

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_eof_reg;

    logic [ROW_W-1:0] mul_a;
    logic [PW-1:0]    mul_p;
    logic             k_lt_total, is_pix, eof;
    logic [ROW_W-1:0] rlo, rhi;
    logic [CW-1:0]    clo, chi;
    logic [SW-1:0]    slot_lo;
    logic [RX-1:0]    rhi_a, hm1;
    logic [CX-1:0]    chi_a, wm1;
    logic [SW:0]      slot_wrap;
    logic [AW-1:0]    raddr, waddr;
    logic [PIX_W-1:0] rdata, v;
    logic [PIX_W-1:0] res_pix;

    assign mul_p = PW'(mul_a) * PW'(w_eff);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_TOTAL: mul_a = ROW_W'(h_eff);
            MUL_KPOS:  mul_a = irow_reg;
            MUL_JPOS:  mul_a = orow_reg;
            MUL_LAG:   mul_a = ROW_W'(rad_eff);
            default:   mul_a = '0;
        endcase
    end

    assign k_lt_total = kpos_reg < total_reg;
    assign is_pix     = (op_reg == OP_PIXEL) && k_lt_total;
    assign eof        = (jpos_reg + PW'(1)) >= total_reg;

    assign st.geom_bad  = (icol_reg >= w_eff) || (ocol_reg >= w_eff) ||
                          (jpos_reg >= total_reg) || (kpos_reg < jpos_reg);
    assign st.skip      = (op_reg == OP_DRAIN) && k_lt_total;
    assign st.emit      = {1'b0, kpos_reg} >= ({1'b0, jpos_reg} + {1'b0, lag_reg});
    assign st.out_busy  = out_valid_reg && !out_ready;

    // clipped window bounds
    assign rhi_a   = RX'(orow_reg) + RX'(rad_eff);
    assign hm1     = RX'(h_eff) - RX'(1);
    assign rlo     = (orow_reg >= ROW_W'(rad_eff)) ? orow_reg - ROW_W'(rad_eff) : '0;
    assign rhi     = (rhi_a > hm1) ? ROW_W'(hm1) : ROW_W'(rhi_a);
    assign chi_a   = CX'(ocol_reg) + CX'(rad_eff);
    assign wm1     = CX'(w_eff) - CX'(1);
    assign clo     = (ocol_reg >= CW'(rad_eff)) ? ocol_reg - CW'(rad_eff) : '0;
    assign chi     = (chi_a > wm1) ? CW'(wm1) : CW'(chi_a);
    assign slot_wrap = (SW+1)'(oslot_reg) + (SW+1)'(STORE_ROWS) - (SW+1)'(rad_eff);
    assign slot_lo = (orow_reg < ROW_W'(rad_eff)) ? '0 :
                     (oslot_reg >= SW'(rad_eff)) ? oslot_reg - SW'(rad_eff) :
                     SW'(slot_wrap);

    assign st.scan_last = (r_reg == rhi) && (c_reg == chi);

    assign raddr = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(c_reg);
    assign waddr = AW'(islot_reg) * AW'(MAX_WIDTH) + AW'(icol_reg);

    ewf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.finish && is_pix),
        .waddr (waddr),
        .wdata (pix_reg),
        .re    (cmd.scan_step),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign v       = sub_flag_reg ? pix_reg : rdata;
    assign res_pix = ((hi_reg - centre_reg) <= (centre_reg - lo_reg)) ? hi_reg : lo_reg;

    // scan walk and min/max accumulation
    always_comb
    begin
        r_next      = r_reg;
        c_next      = c_reg;
        slot_next   = slot_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        centre_next = centre_reg;
        if (cmd.scan_init)
        begin
            r_next    = rlo;
            c_next    = clo;
            slot_next = slot_lo;
            lo_next   = PIX_MAX;
            hi_next   = '0;
        end
        else if (cmd.scan_step)
        begin
            if (c_reg == chi)
            begin
                c_next    = clo;
                r_next    = r_reg + ROW_W'(1);
                slot_next = (slot_reg == SW'(STORE_ROWS - 1)) ? '0 : slot_reg + SW'(1);
            end
            else
            begin
                c_next = c_reg + CW'(1);
            end
        end
        if (rd_valid_reg)
        begin
            if (v < lo_reg)
            begin
                lo_next = v;
            end
            if (v > hi_reg)
            begin
                hi_next = v;
            end
            if (centre_flag_reg)
            begin
                centre_next = v;
            end
        end
    end

    // counter updates
    always_comb
    begin
        icol_next  = icol_reg;
        irow_next  = irow_reg;
        islot_next = islot_reg;
        ocol_next  = ocol_reg;
        orow_next  = orow_reg;
        oslot_next = oslot_reg;
        kpos_next  = kpos_reg;
        jpos_next  = jpos_reg;
        if (cmd.mul_en && cmd.mul_sel == MUL_KPOS)
        begin
            kpos_next = mul_p + PW'(icol_reg);
        end
        if (cmd.mul_en && cmd.mul_sel == MUL_JPOS)
        begin
            jpos_next = mul_p + PW'(ocol_reg);
        end
        if (cmd.finish)
        begin
            if (icol_reg + CW'(1) >= w_eff)
            begin
                icol_next  = '0;
                irow_next  = irow_reg + ROW_W'(1);
                islot_next = (islot_reg == SW'(STORE_ROWS - 1)) ? '0 : islot_reg + SW'(1);
            end
            else
            begin
                icol_next = icol_reg + CW'(1);
            end
            if (st.emit && !eof)
            begin
                if (ocol_reg + CW'(1) >= w_eff)
                begin
                    ocol_next  = '0;
                    orow_next  = orow_reg + ROW_W'(1);
                    oslot_next = (oslot_reg == SW'(STORE_ROWS - 1)) ? '0 :
                                 oslot_reg + SW'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + CW'(1);
                end
            end
        end
        if (cmd.clear_cnt || (cmd.finish && st.emit && eof))
        begin
            icol_next  = '0;
            irow_next  = '0;
            islot_next = '0;
            ocol_next  = '0;
            orow_next  = '0;
            oslot_next = '0;
            kpos_next  = '0;
            jpos_next  = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish && st.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icol_reg      <= '0;
            irow_reg      <= '0;
            islot_reg     <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            oslot_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            icol_reg      <= icol_next;
            irow_reg      <= irow_next;
            islot_reg     <= islot_next;
            ocol_reg      <= ocol_next;
            orow_reg      <= orow_next;
            oslot_reg     <= oslot_next;
            rd_valid_reg  <= cmd.scan_step;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_opcode;
            pix_reg <= in_pixel;
        end
        if (cmd.mul_en && cmd.mul_sel == MUL_TOTAL)
        begin
            total_reg <= mul_p;
        end
        if (cmd.mul_en && cmd.mul_sel == MUL_LAG)
        begin
            lag_reg <= mul_p + PW'(rad_eff);
        end
        kpos_reg        <= kpos_next;
        jpos_reg        <= jpos_next;
        r_reg           <= r_next;
        c_reg           <= c_next;
        slot_reg        <= slot_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        centre_reg      <= centre_next;
        centre_flag_reg <= (r_reg == orow_reg) && (c_reg == ocol_reg);
        sub_flag_reg    <= is_pix && (r_reg == irow_reg) && (c_reg == icol_reg);
        if (cmd.finish && st.emit)
        begin
            out_pix_reg <= res_pix;
            out_eof_reg <= eof;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pix_reg;
    assign out_eof   = out_eof_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (islot_reg < SW'(STORE_ROWS)) && (oslot_reg < SW'(STORE_ROWS)))
        else $error("row slot out of range");

    a_rd_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(cmd.scan_step))
        else $error("read data without a scan step");

    a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && st.emit) |-> (lo_reg <= hi_reg))
        else $error("window min above max at result load");

endmodule

// ===== dv/tb_ewf_if.sv =====
`timescale 1ns / 100ps

package tb_ewf_pkg;
    import ewf_pkg::*;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pix;
    } pix_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eof;
    } filt_res_t;

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import ewf_pkg::*, tb_ewf_pkg::*; ();

    localparam int LW = 1024;
    localparam int LR = 7;
    localparam int SROWS = 2 * LR + 1;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    ewf_pix_if pix_ch ();
    ewf_res_if res_ch ();

    extremum_window_filter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_ch.sink),
        .res_out (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ---------------- filter prediction state ----------------
    logic [PIX_W-1:0] mdl_store [SROWS*LW];
    int unsigned mdl_icol, mdl_irow, mdl_ocol, mdl_orow;
    int unsigned cfg_w, cfg_h, cfg_r;

    pix_item_t pend_q[$];     // items waiting for the driver
    filt_res_t exp_q[$];      // expected results, oldest first
    int fail_cnt;
    int res_seen;
    int frames_done;
    bit hold_sender;          // driver pauses when set
    bit long_hold_req;        // monitor long stall request

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // Compute the expected result, if any, of one accepted transfer.
    task automatic predict_filter(input pix_item_t it);
        longint unsigned w, h, rad, total, k, j;
        bit is_pix, emit;
        int r, c, lo, hi, ctr, v;
        filt_res_t res;
        w = (cfg_w < 1) ? 1 : ((cfg_w > LW) ? LW : cfg_w);
        h = (cfg_h < 1) ? 1 : cfg_h;
        rad = (cfg_r > LR) ? LR : cfg_r;
        total = h * w;
        k = mdl_irow * w + mdl_icol;
        j = mdl_orow * w + mdl_ocol;
        if (mdl_icol >= w || mdl_ocol >= w || j >= total || k < j)
        begin
            mdl_icol = 0; mdl_irow = 0; mdl_ocol = 0; mdl_orow = 0;
            k = 0; j = 0;
        end
        is_pix = (it.op == OP_PIXEL) && (k < total);
        if (!is_pix && k < total)
            return;
        emit = (k >= j + rad * w + rad);
        if (emit)
        begin
            lo = 255; hi = 0; ctr = 0;
            for (r = int'(mdl_orow) - int'(rad); r <= int'(mdl_orow) + int'(rad); r++)
            begin
                if (r < 0 || r >= int'(h))
                    continue;
                for (c = int'(mdl_ocol) - int'(rad); c <= int'(mdl_ocol) + int'(rad); c++)
                begin
                    if (c < 0 || c >= int'(w))
                        continue;
                    if (is_pix && r == int'(mdl_irow) && c == int'(mdl_icol))
                        v = it.pix;
                    else
                        v = mdl_store[(r % SROWS) * LW + c];
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                    if (r == int'(mdl_orow) && c == int'(mdl_ocol)) ctr = v;
                end
            end
            res.pix = ((hi - ctr) <= (ctr - lo)) ? hi[7:0] : lo[7:0];
            res.eof = (j + 1 >= total);
            exp_q.push_back(res);
        end
        if (is_pix)
            mdl_store[(mdl_irow % SROWS) * LW + mdl_icol] = it.pix;
        mdl_icol++;
        if (mdl_icol >= w)
        begin
            mdl_icol = 0;
            mdl_irow++;
        end
        if (emit)
        begin
            if (res.eof)
            begin
                mdl_icol = 0; mdl_irow = 0; mdl_ocol = 0; mdl_orow = 0;
            end
            else if (++mdl_ocol >= w)
            begin
                mdl_ocol = 0;
                mdl_orow++;
            end
        end
    endtask

    // ---------------- clock, reset, limit ----------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

    // Short gaps mostly, occasionally long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ---------------- driver ----------------
    int drv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ch.valid       <= 1'b0;
            pix_ch.opcode      <= OP_PIXEL;
            pix_ch.pixel_value <= '0;
            drv_gap = 0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                predict_filter('{op: pix_ch.opcode, pix: pix_ch.pixel_value});
                void'(pend_q.pop_front());
                drv_gap = pick_gap();
            end
            if (!(pix_ch.valid && !pix_ch.ready))
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    pix_ch.valid <= 1'b0;
                end
                else if (pend_q.size() > 0 && !hold_sender)
                begin
                    pix_ch.valid       <= 1'b1;
                    pix_ch.opcode      <= pend_q[0].op;
                    pix_ch.pixel_value <= pend_q[0].pix;
                end
                else
                    pix_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    int mon_gap;
    int long_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            mon_gap = 0;
            long_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                res_seen++;
                if (exp_q.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    if (res_ch.result_pixel !== exp_q[0].pix)
                        report_mismatch($sformatf("result_pixel got %0d want %0d",
                            res_ch.result_pixel, exp_q[0].pix));
                    if (res_ch.end_of_frame !== exp_q[0].eof)
                        report_mismatch($sformatf("end_of_frame got %0b want %0b",
                            res_ch.end_of_frame, exp_q[0].eof));
                    if (exp_q[0].eof) frames_done++;
                    void'(exp_q.pop_front());
                end
                mon_gap = pick_gap();
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_left = 3000;
            end
            if (long_left > 0)
            begin
                long_left--;
                res_ch.ready <= 1'b0;
            end
            else if (mon_gap > 0)
            begin
                mon_gap--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ---------------- configuration ----------------
    task automatic apb_write(input logic [1:0] idx, input int unsigned val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = val & 32'h7FF;
            REG_HEIGHT: cfg_h = val & 32'h1FFF;
            default:    cfg_r = val & 32'h7;
        endcase
    endtask

    // Wait for all queued transfers and results, then settle.
    task automatic wait_idle();
        while (pend_q.size() > 0 || exp_q.size() > 0 || pix_ch.valid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned r);
        wait_idle();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_RADIUS, r);
    endtask

    // One frame: pixels (with noise drains in mode 1), then enough drains to flush.
    task automatic queue_frame(input int mode);
        int unsigned w, h, rad, n, i;
        w = (cfg_w < 1) ? 1 : cfg_w;
        h = (cfg_h < 1) ? 1 : cfg_h;
        rad = cfg_r;
        n = w * h;
        for (i = 0; i < n; i++)
        begin
            if (mode == 1 && $urandom_range(15) == 0)
                pend_q.push_back('{op: OP_DRAIN, pix: 8'($urandom)});
            case (mode)
                2:       pend_q.push_back('{op: OP_PIXEL,
                             pix: ($urandom_range(1)) ? 8'd255 : 8'd0});
                default: pend_q.push_back('{op: OP_PIXEL, pix: 8'($urandom)});
            endcase
        end
        if (mode == 1)
            pend_q.push_back('{op: OP_PIXEL, pix: 8'($urandom)});
        for (i = 0; i < rad * w + rad; i++)
            pend_q.push_back('{op: OP_DRAIN, pix: 8'($urandom)});
    endtask

    int items_sent;
    int unsigned rw, rh, rr;
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        fail_cnt = 0; res_seen = 0; frames_done = 0;
        hold_sender = 1'b0; long_hold_req = 1'b0;
        mdl_icol = 0; mdl_irow = 0; mdl_ocol = 0; mdl_orow = 0;
        cfg_w = 640; cfg_h = 480; cfg_r = 1;
        foreach (mdl_store[i]) mdl_store[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: single pixel frame, extremes, all-extreme content.
        set_geometry(1, 1, 0);
        pend_q.push_back('{op: OP_DRAIN, pix: 8'd0});
        pend_q.push_back('{op: OP_PIXEL, pix: 8'd255});
        pend_q.push_back('{op: OP_PIXEL, pix: 8'd0});
        set_geometry(4, 3, 1);
        queue_frame(2);
        set_geometry(3, 2, 7);
        queue_frame(0);
        set_geometry(1, 5, 2);
        queue_frame(1);
        set_geometry(0, 0, 3);
        queue_frame(0);

        // Long receiver stall while the sender keeps offering.
        set_geometry(8, 6, 2);
        long_hold_req = 1'b1;
        queue_frame(0);
        queue_frame(1);

        // Sender waits for all results.
        wait_idle();
        hold_sender = 1'b1;
        repeat (50) @(posedge clk);
        hold_sender = 1'b0;

        // Random frames, mostly small.
        items_sent = 0;
        while (items_sent < 200)
        begin
            if ($urandom_range(19) == 0)
            begin
                rw = $urandom_range(40, 20); rh = $urandom_range(3, 1);
            end
            else
            begin
                rw = $urandom_range(9, 1); rh = $urandom_range(7, 1);
            end
            rr = $urandom_range(7);
            set_geometry(rw, rh, rr);
            queue_frame($urandom_range(2));
            items_sent += rw * rh + rr * rw + rr;
        end
        set_geometry(1024, 1, 0);
        queue_frame(0);
        set_geometry(640, 4096, 1);
        wait_idle();

        $display("Covered %0d frames, %0d results checked, geometries 1x1 to 1024 wide.",
                 frames_done, res_seen);
        if (fail_cnt == 0 && exp_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
